// ===== rtl/tss_pkg.sv =====
// Shared types, widths and constants of the tape saturation sample kernel.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps
package tss_pkg;

    // Internal fixed point: signed Q5.27
    localparam int Q_W        = 32;
    localparam int FRAC       = 27;
    localparam int SMP_W      = 24;
    localparam int MAX_SPAN   = 32;
    localparam int STAGES     = 5;
    localparam int POS_W      = 5;

    // Shared multiplier operand and product widths
    localparam int MA_W       = 48;
    localparam int MB_W       = 34;
    localparam int P_W        = MA_W + MB_W;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_INPUT_GAIN  = 3'd0;
    localparam logic [2:0] REG_OUTPUT_GAIN = 3'd1;
    localparam logic [2:0] REG_WET_MIX     = 3'd2;
    localparam logic [2:0] REG_AVG_SPAN    = 3'd3;
    localparam logic [2:0] REG_SLEW_SCALE  = 3'd4;

    // Control of one averaging ring
    typedef struct packed {
        logic rd;
        logic upd;
    } t_ring_ctl;

    // Saturate a wide signed value to 32 bits
    function automatic logic signed [Q_W-1:0] sat32(input logic signed [P_W-1:0] v);
        if (v[P_W-1:Q_W-1] == '0 || v[P_W-1:Q_W-1] == '1) begin
            return v[Q_W-1:0];
        end
        return v[P_W-1] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
    endfunction

    // Saturate a wide signed value to the sample width
    function automatic logic signed [SMP_W-1:0] sat24(input logic signed [P_W-1:0] v);
        if (v[P_W-1:SMP_W-1] == '0 || v[P_W-1:SMP_W-1] == '1) begin
            return v[SMP_W-1:0];
        end
        return v[P_W-1] ? {1'b1, {(SMP_W-1){1'b0}}} : {1'b0, {(SMP_W-1){1'b1}}};
    endfunction

endpackage

// ===== rtl/tss_mul.sv =====
// Shared two-pass signed multiplier: 48-bit by 34-bit in two 24-bit halves.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_mul (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [tss_pkg::MA_W-1:0] i_a,
    input  logic signed [tss_pkg::MB_W-1:0] i_b,
    output logic                            o_done,
    output logic signed [tss_pkg::P_W-1:0]  o_prod
);
    import tss_pkg::*;

    localparam int SPLIT = MA_W / 2;

    logic signed [SPLIT+MB_W:0]        plo_w;
    logic signed [SPLIT+MB_W-1:0]      phi_w;
    logic signed [SPLIT+MB_W:0]        r_plo;
    logic signed [MA_W-SPLIT-1:0]      r_ahi;
    logic signed [MB_W-1:0]            r_b;
    logic                              r_ph1;
    logic                              r_done;
    logic signed [P_W-1:0]             r_prod;

    // Low half unsigned, high half signed
    always_comb begin
        plo_w = $signed({1'b0, i_a[SPLIT-1:0]}) * i_b;
        phi_w = r_ahi * r_b;
    end

    // Sequence the two passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph1  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_ph1  <= i_start;
            r_done <= r_ph1;
        end
    end

    // Hold partial product, then combine
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_plo <= plo_w;
            r_ahi <= i_a[MA_W-1:SPLIT];
            r_b   <= i_b;
        end
        if (r_ph1) begin
            r_prod <= (P_W'(phi_w) <<< SPLIT) + P_W'(r_plo);
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== rtl/tss_ring.sv =====
// One moving-average ring: tap memory, valid bits and a running sum.
// Depends on tss_pkg.
`timescale 1ns / 1ps
module tss_ring #(
    parameter int DEPTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tss_pkg::t_ring_ctl             i_ctl,
    input  logic [tss_pkg::POS_W-1:0]      i_pos,
    input  logic signed [tss_pkg::Q_W-1:0] i_val,
    output logic signed [tss_pkg::Q_W-1:0] o_avg
);
    import tss_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int SW = Q_W + AW;

    logic signed [Q_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]      r_vld;
    logic signed [Q_W-1:0] r_old;
    logic                  r_oldv;
    logic signed [SW-1:0]  r_sum;
    logic signed [SW-1:0]  n_sum;
    logic signed [Q_W-1:0] old_w;
    logic [AW-1:0]         addr;

    assign addr  = i_pos[AW-1:0];
    assign old_w = r_oldv ? r_old : '0;
    assign n_sum = r_sum - SW'(old_w) + SW'(i_val);
    assign o_avg = Q_W'(n_sum >>> AW);

    // Read the tap that is about to be replaced
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            r_old <= mem[addr];
        end
        if (i_ctl.upd) begin
            mem[addr] <= i_val;
        end
    end

    // Track valid taps and the running sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_oldv <= 1'b0;
            r_sum  <= '0;
        end else begin
            if (i_ctl.rd) begin
                r_oldv <= r_vld[addr];
            end
            if (i_ctl.upd) begin
                r_vld[addr] <= 1'b1;
                r_sum       <= n_sum;
            end
        end
    end

endmodule

// ===== rtl/tape_saturation_sample_kernel.sv =====
// Top level of the tape saturation sample kernel: configuration registers,
// sequencer, shared multiplier and averaging rings. Depends on tss_pkg, tss_mul, tss_ring.
`timescale 1ns / 1ps
// One mono sample is taken per beat and gives one result beat. The time per
// sample depends on how many averaging stages the span enables, and the block
// is not ready while it works. Twenty products pass through one shared
// two-pass multiplier. Each enabled stage of both cascades reads its ring in
// S_CRD and then updates it in S_CUP, a disabled stage only passes through
// S_CRD, and each cascade ends with the hand-off state S_CEND. S_OUT moves
// the result to the output register and S_IDLE waits for the next beat. A finished result
// waits in an output register, so the next sample may start while it is still
// unclaimed; the sequencer only stalls at the end if that register is still full.
// The user writes registers over the APB port only while the block is idle;
// the block does not enforce it. Rings start cleared after reset, with no clearing pass.
module tape_saturation_sample_kernel (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [4:0]                        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [tss_pkg::SMP_W-1:0]  i_in_sample,
    input  logic                              i_frame_last,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [tss_pkg::SMP_W-1:0]  o_out_sample,
    output logic                              o_frame_last_out
);
    import tss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_CRD  = 3'd2;
    localparam logic [2:0] S_CUP  = 3'd3;
    localparam logic [2:0] S_CEND = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    localparam logic [4:0] M_GAIN = 5'd0;
    localparam logic [4:0] M_SLEW = 5'd1;
    localparam logic [4:0] M_B1A  = 5'd2;
    localparam logic [4:0] M_B1B  = 5'd3;
    localparam logic [4:0] M_X2   = 5'd4;
    localparam logic [4:0] M_P3   = 5'd5;
    localparam logic [4:0] M_P5   = 5'd6;
    localparam logic [4:0] M_P7   = 5'd7;
    localparam logic [4:0] M_P9   = 5'd8;
    localparam logic [4:0] M_P11  = 5'd9;
    localparam logic [4:0] M_T3   = 5'd10;
    localparam logic [4:0] M_T5   = 5'd11;
    localparam logic [4:0] M_T7   = 5'd12;
    localparam logic [4:0] M_T9   = 5'd13;
    localparam logic [4:0] M_T11  = 5'd14;
    localparam logic [4:0] M_B2A  = 5'd15;
    localparam logic [4:0] M_B2B  = 5'd16;
    localparam logic [4:0] M_OG   = 5'd17;
    localparam logic [4:0] M_WET  = 5'd18;
    localparam logic [4:0] M_DRY  = 5'd19;

    localparam logic [28:0]          ONE_Q  = 29'h0800_0000;
    localparam logic [28:0]          TWO_Q  = 29'h1000_0000;
    localparam logic signed [Q_W-1:0] CLIP_Q = 32'sd309496552;
    localparam logic [16:0]          UNITY  = 17'h1_0000;
    localparam logic [MB_W-1:0]      C3  = 34'd715827883;
    localparam logic [MB_W-1:0]      C5  = 34'd62245903;
    localparam logic [MB_W-1:0]      C7  = 34'd1697562;
    localparam logic [MB_W-1:0]      C9  = 34'd19090;
    localparam logic [MB_W-1:0]      C11 = 34'd430;

    // Configuration registers
    logic [15:0] r_igain, r_ogain;
    logic [16:0] r_wet, r_slew;
    logic [5:0]  r_span;

    // Sequencer and datapath registers
    logic [2:0]             r_state;
    logic [4:0]             r_step;
    logic                   r_cas;
    logic [2:0]             r_k;
    logic [POS_W-1:0]       r_pos;
    logic                   r_start;
    logic signed [MA_W-1:0] r_ma;
    logic signed [MB_W-1:0] r_mb;
    logic signed [SMP_W-1:0] r_dry;
    logic                   r_flag;
    logic signed [Q_W-1:0]  r_x, r_avg, r_prev, r_v, r_y, r_cv, r_x2, r_x2h;
    logic signed [MA_W-1:0] r_p3, r_p5, r_p7, r_p9, r_p11, r_ya;
    logic [28:0]            r_w;
    logic signed [P_W-1:0]  r_acc;
    logic signed [SMP_W-1:0] r_res;
    logic                   r_ovalid;
    logic signed [SMP_W-1:0] r_osmp;
    logic                   r_oflag;

    logic                   mul_done;
    logic signed [P_W-1:0]  mul_prod;
    logic signed [P_W-1:0]  acc_sum;
    logic signed [Q_W-1:0]  blend_v, clip_v;
    logic signed [MA_W-1:0] term;
    logic signed [MA_W-1:0] y_add, y_sub;
    logic signed [P_W-1:0]  s_prod;
    logic [28:0]            w_new;
    logic signed [Q_W:0]    diff;
    logic [Q_W:0]           diff_abs;
    logic [5:0]             span_c;
    logic [STAGES-1:0]      en;
    logic signed [Q_W-1:0]  pre_avg [STAGES];
    logic signed [Q_W-1:0]  post_avg [STAGES];
    logic signed [Q_W-1:0]  avg_sel;
    t_ring_ctl              pre_ctl [STAGES];
    t_ring_ctl              post_ctl [STAGES];
    logic                   cfg_wr;

    // APB register file
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_igain <= 16'd4096;
            r_ogain <= 16'd60548;
            r_wet   <= 17'd65536;
            r_span  <= 6'd2;
            r_slew  <= 17'd7864;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_INPUT_GAIN:  r_igain <= pwdata[15:0];
                REG_OUTPUT_GAIN: r_ogain <= pwdata[15:0];
                REG_WET_MIX:     r_wet   <= pwdata[16:0];
                REG_AVG_SPAN:    r_span  <= pwdata[5:0];
                REG_SLEW_SCALE:  r_slew  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_INPUT_GAIN:  prdata = 32'(r_igain);
            REG_OUTPUT_GAIN: prdata = 32'(r_ogain);
            REG_WET_MIX:     prdata = 32'(r_wet);
            REG_AVG_SPAN:    prdata = 32'(r_span);
            REG_SLEW_SCALE:  prdata = 32'(r_slew);
            default:         prdata = '0;
        endcase
    end

    // Clamp span and pick the enabled stages
    always_comb begin
        if (r_span < 6'd2) begin
            span_c = 6'd2;
        end else if (r_span > 6'(MAX_SPAN)) begin
            span_c = 6'(MAX_SPAN);
        end else begin
            span_c = r_span;
        end
        en[0] = span_c > 6'd31;
        en[1] = span_c > 6'd15;
        en[2] = span_c > 6'd7;
        en[3] = span_c > 6'd3;
        en[4] = span_c > 6'd1;
    end

    // Shared multiplier
    tss_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_a     (r_ma),
        .i_b     (r_mb),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    // Averaging rings of both cascades
    for (genvar g = 0; g < STAGES; g++) begin : g_ring
        always_comb begin
            pre_ctl[g].rd   = (r_state == S_CRD) && en[g] && !r_cas && (r_k == 3'(g));
            pre_ctl[g].upd  = (r_state == S_CUP) && !r_cas && (r_k == 3'(g));
            post_ctl[g].rd  = (r_state == S_CRD) && en[g] && r_cas && (r_k == 3'(g));
            post_ctl[g].upd = (r_state == S_CUP) && r_cas && (r_k == 3'(g));
        end

        tss_ring #(.DEPTH(MAX_SPAN >> g)) u_pre (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (pre_ctl[g]),
            .i_pos   (r_pos),
            .i_val   (r_cv),
            .o_avg   (pre_avg[g])
        );

        tss_ring #(.DEPTH(MAX_SPAN >> g)) u_post (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (post_ctl[g]),
            .i_pos   (r_pos),
            .i_val   (r_cv),
            .o_avg   (post_avg[g])
        );
    end

    // Result shaping around the multiplier
    always_comb begin
        avg_sel  = r_cas ? post_avg[r_k] : pre_avg[r_k];
        acc_sum  = r_acc + mul_prod;
        blend_v  = sat32(acc_sum >>> FRAC);
        if (blend_v > CLIP_Q) begin
            clip_v = CLIP_Q;
        end else if (blend_v < -CLIP_Q) begin
            clip_v = -CLIP_Q;
        end else begin
            clip_v = blend_v;
        end
        term     = MA_W'(mul_prod >>> 32);
        y_add    = r_ya + term;
        y_sub    = r_ya - term;
        s_prod   = mul_prod >>> 16;
        w_new    = (s_prod > $signed(P_W'(ONE_Q))) ? TWO_Q : {s_prod[27:0], 1'b0};
        diff     = (Q_W+1)'(r_prev) - (Q_W+1)'(r_x);
        diff_abs = diff[Q_W] ? (Q_W+1)'(-diff) : diff;
    end

    assign o_in_ready = (r_state == S_IDLE);

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= M_GAIN;
            r_start  <= 1'b0;
            r_cas    <= 1'b0;
            r_k      <= '0;
            r_pos    <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_dry   <= i_in_sample;
                        r_flag  <= i_frame_last;
                        r_ma    <= MA_W'(i_in_sample);
                        r_mb    <= MB_W'(r_igain);
                        r_step  <= M_GAIN;
                        r_start <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_start <= 1'b1;
                        r_step  <= r_step + 5'd1;
                        unique case (r_step)
                            M_GAIN: begin
                                r_x     <= sat32(mul_prod >>> 8);
                                r_cv    <= sat32(mul_prod >>> 8);
                                r_cas   <= 1'b0;
                                r_k     <= '0;
                                r_start <= 1'b0;
                                r_state <= S_CRD;
                            end
                            M_SLEW: begin
                                r_w  <= w_new;
                                r_ma <= MA_W'(r_x);
                                r_mb <= MB_W'(ONE_Q) - MB_W'(w_new);
                            end
                            M_B1A: begin
                                r_acc <= mul_prod;
                                r_ma  <= MA_W'(r_avg);
                                r_mb  <= MB_W'(r_w);
                            end
                            M_B1B: begin
                                r_v  <= clip_v;
                                r_ma <= MA_W'(clip_v);
                                r_mb <= MB_W'(clip_v);
                            end
                            M_X2: begin
                                r_x2  <= Q_W'(mul_prod >>> FRAC);
                                r_x2h <= Q_W'(mul_prod >>> (FRAC + 8));
                                r_ma  <= MA_W'(r_v);
                                r_mb  <= MB_W'(Q_W'(mul_prod >>> FRAC));
                            end
                            M_P3: begin
                                r_p3 <= MA_W'(mul_prod >>> FRAC);
                                r_ma <= MA_W'(mul_prod >>> FRAC);
                                r_mb <= MB_W'(r_x2);
                            end
                            M_P5: begin
                                r_p5 <= MA_W'(mul_prod >>> FRAC);
                                r_ma <= MA_W'(mul_prod >>> FRAC);
                                r_mb <= MB_W'(r_x2);
                            end
                            M_P7: begin
                                r_p7 <= MA_W'(mul_prod >>> FRAC);
                                r_ma <= MA_W'(mul_prod >>> FRAC);
                                r_mb <= MB_W'(r_x2h);
                            end
                            M_P9: begin
                                r_p9 <= MA_W'(mul_prod >>> (FRAC - 8));
                                r_ma <= MA_W'(mul_prod >>> (FRAC - 8));
                                r_mb <= MB_W'(r_x2h);
                            end
                            M_P11: begin
                                r_p11 <= MA_W'(mul_prod >>> (FRAC - 8));
                                r_ya  <= MA_W'(r_v);
                                r_ma  <= r_p3;
                                r_mb  <= C3;
                            end
                            M_T3: begin
                                r_ya <= y_sub;
                                r_ma <= r_p5;
                                r_mb <= C5;
                            end
                            M_T5: begin
                                r_ya <= y_add;
                                r_ma <= r_p7;
                                r_mb <= C7;
                            end
                            M_T7: begin
                                r_ya <= y_sub;
                                r_ma <= r_p9;
                                r_mb <= C9;
                            end
                            M_T9: begin
                                r_ya <= y_add;
                                r_ma <= r_p11;
                                r_mb <= C11;
                            end
                            M_T11: begin
                                r_y     <= sat32(P_W'(y_sub));
                                r_cv    <= sat32(P_W'(y_sub));
                                r_cas   <= 1'b1;
                                r_k     <= '0;
                                r_start <= 1'b0;
                                r_state <= S_CRD;
                            end
                            M_B2A: begin
                                r_acc <= mul_prod;
                                r_ma  <= MA_W'(r_cv);
                                r_mb  <= MB_W'(r_w);
                            end
                            M_B2B: begin
                                r_ma <= MA_W'(blend_v);
                                r_mb <= MB_W'(r_ogain);
                            end
                            M_OG: begin
                                r_ma <= MA_W'(mul_prod >>> 16);
                                r_mb <= MB_W'(r_wet);
                            end
                            M_WET: begin
                                r_acc <= mul_prod;
                                r_ma  <= MA_W'(r_dry) <<< 4;
                                r_mb  <= MB_W'(UNITY) - MB_W'(r_wet);
                            end
                            M_DRY: begin
                                r_res   <= sat24(acc_sum >>> 20);
                                r_start <= 1'b0;
                                r_state <= S_OUT;
                            end
                            default: begin
                                r_start <= 1'b0;
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CRD: begin
                    if (en[r_k]) begin
                        r_state <= S_CUP;
                    end else if (r_k == 3'(STAGES - 1)) begin
                        r_state <= S_CEND;
                    end else begin
                        r_k <= r_k + 3'd1;
                    end
                end
                S_CUP: begin
                    r_cv <= avg_sel;
                    if (r_k == 3'(STAGES - 1)) begin
                        r_state <= S_CEND;
                    end else begin
                        r_k     <= r_k + 3'd1;
                        r_state <= S_CRD;
                    end
                end
                S_CEND: begin
                    r_start <= 1'b1;
                    r_state <= S_MUL;
                    if (!r_cas) begin
                        r_avg  <= r_cv;
                        r_prev <= r_cv;
                        r_ma   <= MA_W'(diff_abs);
                        r_mb   <= MB_W'(r_slew);
                        r_step <= M_SLEW;
                    end else begin
                        r_pos  <= r_pos + POS_W'(1);
                        r_ma   <= MA_W'(r_y);
                        r_mb   <= MB_W'(ONE_Q) - MB_W'(r_w);
                        r_step <= M_B2A;
                    end
                end
                // Hold the result until the output register is free
                S_OUT: begin
                    if (!r_ovalid || i_out_ready) begin
                        r_ovalid <= 1'b1;
                        r_osmp   <= r_res;
                        r_oflag  <= r_flag;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_ovalid;
    assign o_out_sample     = r_osmp;
    assign o_frame_last_out = r_oflag;

endmodule
